// ===== rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helper functions for the JSON string unescape block.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int BYTE_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int MAX_BYTES   = 4;
    localparam int CNT_W       = 3;   // holds 0..MAX_BYTES
    localparam int IDX_W       = 2;   // indexes MAX_BYTES entries
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CP_W        = 21;

    // done status codes
    localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CONTROL       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNTERMINATED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_ESCAPE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_HEX       = 3'd4;
    localparam logic [STATUS_W-1:0] ST_MISSING_LOW   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_BAD_LOW       = 3'd6;
    localparam logic [STATUS_W-1:0] ST_UNEXPECTED_LOW = 3'd7;

    // one queue entry: either a run of decoded bytes or a done marker
    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]                 count;
        logic                             done;
        logic [STATUS_W-1:0]              status;
    } jsu_cmd_t;

    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]                 count;
    } jsu_utf8_t;

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_val(input logic [BYTE_W-1:0] b);
        logic [4:0] v;
        v = 5'd16;
        if (b >= 8'h30 && b <= 8'h39)
            v = {1'b0, 4'(b - 8'h30)};
        else if (b >= 8'h61 && b <= 8'h66)
            v = {1'b0, 4'(b - 8'h61 + 8'd10)};
        else if (b >= 8'h41 && b <= 8'h46)
            v = {1'b0, 4'(b - 8'h41 + 8'd10)};
        return v;
    endfunction

    function automatic jsu_utf8_t utf8_encode(input logic [CP_W-1:0] cp);
        jsu_utf8_t r;
        r.bytes = '0;
        if (cp < 21'h80) begin
            r.bytes[0] = cp[7:0];
            r.count    = 3'd1;
        end
        else if (cp < 21'h800) begin
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
            r.count    = 3'd2;
        end
        else if (cp < 21'h10000) begin
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
            r.count    = 3'd3;
        end
        else begin
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
            r.count    = 3'd4;
        end
        return r;
    endfunction

endpackage

// ===== rtl/jsu_in_if.sv =====
// ----------------------------------------------------------------------------
// jsu_in_if
// Input channel: one raw string byte or an end-of-source mark per beat.
// ----------------------------------------------------------------------------
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       source_end;

    modport source (output valid, output in_byte, output source_end, input ready);
    modport sink   (input valid, input in_byte, input source_end, output ready);
endinterface

// ===== rtl/jsu_out_if.sv =====
// ----------------------------------------------------------------------------
// jsu_out_if
// Output channel: one decoded byte or a done marker with status per beat.
// ----------------------------------------------------------------------------
interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output out_byte, output byte_valid,
                    output string_done, output status, output last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input string_done, input status, input last, output ready);
endinterface

// ===== rtl/json_string_unescape_utf8_core.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core
// JSON string body decoder: unescapes bytes and \u escapes into UTF-8.
// ----------------------------------------------------------------------------
// Usage:
//   item   : one beat per raw byte of the string body, starting after the
//            opening quote; a beat with source_end set marks end of source.
//   result : one beat per decoded byte (byte_valid), or one done beat
//            (string_done) carrying the status; last marks the final beat
//            of the input byte that caused it. Bytes are provisional until
//            the done beat reports status ok.
//   Each decoded run is registered in the queue, then in the output sequencer
//   before its first beat is sent. Throughput: one input byte per cycle while
//   the queue is not full. A \u escape yields up to four UTF-8 bytes, which
//   the output sequencer sends one by one, absorbed by the four-entry queue.
//   Stall: when the receiver holds ready low, the queue fills and item.ready
//   drops once it is full; nothing is lost.
//   Reset: rst_n clears the scan state, the queue and the output stage; the
//   block accepts input as soon as reset is released.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core (
    input  logic      clk,
    input  logic      rst_n,
    jsu_in_if.sink    item,
    jsu_out_if.source result
);
    import jsu_pkg::*;

    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_empty;
    jsu_cmd_t q_in;
    jsu_cmd_t q_out;

    jsu_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    jsu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_out)
    );

    jsu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

// ===== rtl/jsu_front.sv =====
// ----------------------------------------------------------------------------
// jsu_front
// Scanner: takes one byte per cycle unless the queue is full, tracks escape
// state and errors, and pushes a decoded run or a done marker into the queue.
// ----------------------------------------------------------------------------
module jsu_front (
    input  logic             clk,
    input  logic             rst_n,
    jsu_in_if.sink           item,
    input  logic             q_full,
    output logic             q_push,
    output jsu_pkg::jsu_cmd_t q_data
);
    import jsu_pkg::*;

    localparam logic [3:0] M_PLAIN       = 4'd0;
    localparam logic [3:0] M_ESC         = 4'd1;
    localparam logic [3:0] M_HEX         = 4'd2;
    localparam logic [3:0] M_NEED_BS     = 4'd3;
    localparam logic [3:0] M_NEED_U      = 4'd4;
    localparam logic [3:0] M_LOWHEX      = 4'd5;
    localparam logic [3:0] M_LOWPEND     = 4'd6;
    localparam logic [3:0] M_LOWPEND_ESC = 4'd7;
    localparam logic [3:0] M_SKIP        = 4'd8;
    localparam logic [3:0] M_SKIP_ESC    = 4'd9;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CTRL_MAX  = 8'h20;

    logic [3:0]          mode_reg, mode_next;
    logic [15:0]         acc_reg, acc_next;
    logic [9:0]          hsb_reg, hsb_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic [STATUS_W-1:0] esc_reg, esc_next;
    logic [STATUS_W-1:0] str_reg, str_next;

    logic                accept;
    logic [7:0]          b;
    logic [4:0]          v;
    logic [15:0]         acc_shift;
    logic                closed;
    logic                emit_one;
    logic [7:0]          one_byte;
    logic                emit_cp;
    logic [CP_W-1:0]     cp;
    logic                clean;
    jsu_utf8_t           enc;

    assign item.ready = !q_full;
    assign accept     = item.valid && item.ready;
    assign b          = item.in_byte;
    assign v          = hex_val(b);
    assign acc_shift  = {acc_reg[11:0], v[3:0]};
    assign clean      = (esc_reg == ST_OK) && (str_reg == ST_OK);
    assign enc        = utf8_encode(cp);

    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        hsb_next  = hsb_reg;
        cnt_next  = cnt_reg;
        esc_next  = esc_reg;
        str_next  = str_reg;
        closed    = 1'b0;
        emit_one  = 1'b0;
        one_byte  = b;
        emit_cp   = 1'b0;
        cp        = '0;

        case (mode_reg)
            M_PLAIN:
            begin
                if (b == CH_QUOTE)
                    closed = 1'b1;
                else if (b == CH_BSLASH)
                    mode_next = M_ESC;
                else if (b < CTRL_MAX)
                begin
                    if (str_next == ST_OK) str_next = ST_CONTROL;
                    mode_next = M_SKIP;
                end
                else
                    emit_one = 1'b1;
            end
            M_ESC:
            begin
                mode_next = M_PLAIN;
                case (b)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: emit_one = 1'b1;
                    CH_B: begin emit_one = 1'b1; one_byte = 8'h08; end
                    CH_F: begin emit_one = 1'b1; one_byte = 8'h0C; end
                    CH_N: begin emit_one = 1'b1; one_byte = 8'h0A; end
                    CH_R: begin emit_one = 1'b1; one_byte = 8'h0D; end
                    CH_T: begin emit_one = 1'b1; one_byte = 8'h09; end
                    CH_U:
                    begin
                        acc_next  = '0;
                        cnt_next  = '0;
                        mode_next = M_HEX;
                    end
                    default:
                    begin
                        if (esc_next == ST_OK) esc_next = ST_BAD_ESCAPE;
                        mode_next = M_SKIP;
                    end
                endcase
            end
            M_HEX:
            begin
                if (v[4])
                begin
                    if (esc_next == ST_OK) esc_next = ST_BAD_HEX;
                    if (b == CH_QUOTE)
                        closed = 1'b1;
                    else if (b == CH_BSLASH)
                        mode_next = M_SKIP_ESC;
                    else
                    begin
                        if (b < CTRL_MAX && str_next == ST_OK) str_next = ST_CONTROL;
                        mode_next = M_SKIP;
                    end
                end
                else
                begin
                    acc_next = acc_shift;
                    if (cnt_reg != 2'd3)
                        cnt_next = cnt_reg + 2'd1;
                    else
                    begin
                        cnt_next = '0;
                        if (acc_shift inside {[16'hD800:16'hDBFF]})
                        begin
                            hsb_next  = acc_shift[9:0];
                            mode_next = M_NEED_BS;
                        end
                        else if (acc_shift inside {[16'hDC00:16'hDFFF]})
                        begin
                            if (esc_next == ST_OK) esc_next = ST_UNEXPECTED_LOW;
                            mode_next = M_SKIP;
                        end
                        else
                        begin
                            emit_cp   = 1'b1;
                            cp        = {5'd0, acc_shift};
                            mode_next = M_PLAIN;
                        end
                    end
                end
            end
            M_NEED_BS:
            begin
                if (b == CH_BSLASH)
                    mode_next = M_NEED_U;
                else
                begin
                    if (esc_next == ST_OK) esc_next = ST_MISSING_LOW;
                    if (b == CH_QUOTE)
                        closed = 1'b1;
                    else
                    begin
                        if (b < CTRL_MAX && str_next == ST_OK) str_next = ST_CONTROL;
                        mode_next = M_SKIP;
                    end
                end
            end
            M_NEED_U:
            begin
                if (b == CH_U)
                begin
                    acc_next  = '0;
                    cnt_next  = '0;
                    mode_next = M_LOWHEX;
                end
                else
                begin
                    if (esc_next == ST_OK) esc_next = ST_MISSING_LOW;
                    mode_next = M_SKIP;
                end
            end
            M_LOWHEX, M_LOWPEND:
            begin
                if (mode_reg == M_LOWHEX && !v[4])
                begin
                    acc_next = acc_shift;
                    if (cnt_reg != 2'd3)
                        cnt_next = cnt_reg + 2'd1;
                    else
                    begin
                        cnt_next = '0;
                        if (acc_shift inside {[16'hDC00:16'hDFFF]})
                        begin
                            emit_cp   = 1'b1;
                            cp        = 21'h10000 + {1'b0, hsb_reg, acc_shift[9:0]};
                            mode_next = M_PLAIN;
                        end
                        else
                        begin
                            if (esc_next == ST_OK) esc_next = ST_BAD_LOW;
                            mode_next = M_SKIP;
                        end
                    end
                end
                else if (b == CH_QUOTE)
                begin
                    if (esc_next == ST_OK) esc_next = ST_MISSING_LOW;
                    closed = 1'b1;
                end
                else if (cnt_reg == 2'd3)
                begin
                    // sixth raw byte reached without a valid low group
                    if (esc_next == ST_OK) esc_next = ST_BAD_LOW;
                    if (b == CH_BSLASH)
                        mode_next = M_SKIP_ESC;
                    else
                    begin
                        if (b < CTRL_MAX && str_next == ST_OK) str_next = ST_CONTROL;
                        mode_next = M_SKIP;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 2'd1;
                    if (b == CH_BSLASH)
                        mode_next = M_LOWPEND_ESC;
                    else
                    begin
                        if (b < CTRL_MAX && str_next == ST_OK) str_next = ST_CONTROL;
                        mode_next = M_LOWPEND;
                    end
                end
            end
            M_LOWPEND_ESC:
            begin
                if (cnt_reg == 2'd3)
                begin
                    if (esc_next == ST_OK) esc_next = ST_BAD_LOW;
                    mode_next = M_SKIP;
                end
                else
                begin
                    cnt_next  = cnt_reg + 2'd1;
                    mode_next = M_LOWPEND;
                end
            end
            M_SKIP_ESC:
                mode_next = M_SKIP;
            default:
            begin
                if (b == CH_QUOTE)
                    closed = 1'b1;
                else if (b == CH_BSLASH)
                    mode_next = M_SKIP_ESC;
                else
                begin
                    if (b < CTRL_MAX && str_next == ST_OK) str_next = ST_CONTROL;
                    mode_next = M_SKIP;
                end
            end
        endcase

        // build the queue entry
        q_data        = '0;
        q_data.status = ST_OK;
        if (item.source_end)
        begin
            q_data.done   = 1'b1;
            q_data.status = (str_reg != ST_OK) ? str_reg : ST_UNTERMINATED;
        end
        else if (closed)
        begin
            q_data.done   = 1'b1;
            q_data.status = (str_next != ST_OK) ? str_next : esc_next;
        end
        else if (clean && emit_one)
        begin
            q_data.bytes[0] = one_byte;
            q_data.count    = 3'd1;
        end
        else if (clean && emit_cp)
        begin
            q_data.bytes = enc.bytes;
            q_data.count = enc.count;
        end

        // string ends: return to the idle scan state
        if (item.source_end || closed)
        begin
            mode_next = M_PLAIN;
            acc_next  = '0;
            hsb_next  = '0;
            cnt_next  = '0;
            esc_next  = ST_OK;
            str_next  = ST_OK;
        end
    end

    assign q_push = accept && (q_data.done || (q_data.count != '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_PLAIN;
            acc_reg  <= '0;
            hsb_reg  <= '0;
            cnt_reg  <= '0;
            esc_reg  <= ST_OK;
            str_reg  <= ST_OK;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            hsb_reg  <= hsb_next;
            cnt_reg  <= cnt_next;
            esc_reg  <= esc_next;
            str_reg  <= str_next;
        end
    end

endmodule

// ===== rtl/jsu_queue.sv =====
// ----------------------------------------------------------------------------
// jsu_queue
// Small FIFO of decoded runs between the scanner and the output sequencer.
// ----------------------------------------------------------------------------
module jsu_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  jsu_pkg::jsu_cmd_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output jsu_pkg::jsu_cmd_t pop_data
);
    import jsu_pkg::*;

    jsu_cmd_t            store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [QPTR_W:0]     fill_reg, fill_next;
    logic                do_push, do_pop;

    assign full     = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = store_reg[rptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wptr_next = do_push ? QPTR_W'(wptr_reg + 1'b1) : wptr_reg;
        rptr_next = do_pop  ? QPTR_W'(rptr_reg + 1'b1) : rptr_reg;
        fill_next = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// ===== rtl/jsu_back.sv =====
// ----------------------------------------------------------------------------
// jsu_back
// Output sequencer: holds one queue entry and sends its bytes, or its done
// marker, one beat per cycle while the receiver holds ready high.
// ----------------------------------------------------------------------------
module jsu_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  jsu_pkg::jsu_cmd_t q_data,
    output logic             q_pop,
    jsu_out_if.source        result
);
    import jsu_pkg::*;

    jsu_cmd_t          cmd_reg;
    logic              busy_reg, busy_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              is_last;
    logic              fire;
    logic              load;

    assign is_last = cmd_reg.done || ((CNT_W'(idx_reg) + 1'b1) == cmd_reg.count);
    assign fire    = result.valid && result.ready;
    assign load    = !busy_reg || (fire && is_last);
    assign q_pop   = load && !q_empty;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = !q_empty;
            idx_next  = '0;
        end
        else if (fire)
            idx_next = idx_reg + 1'b1;
    end

    assign result.valid       = busy_reg;
    assign result.out_byte    = cmd_reg.done ? '0 : cmd_reg.bytes[idx_reg];
    assign result.byte_valid  = !cmd_reg.done;
    assign result.string_done = cmd_reg.done;
    assign result.status      = cmd_reg.done ? cmd_reg.status : ST_OK;
    assign result.last        = is_last;

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cmd_reg <= q_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

endmodule
